>>> design/awf_pkg.sv
// Shared types, constants and saturation helpers for the A-weighting filter.
package awf_pkg;

	// Sample, coefficient and accumulator widths
	localparam int SAMPLE_WIDTH    = 24;
	localparam int COEF_WIDTH      = 24;
	localparam int COEF_FRAC_BITS  = 24;
	localparam int STATE_FRAC_BITS = 12;
	localparam int GAIN_FRAC_BITS  = 22;
	localparam int ACC_WIDTH       = 40;

	// Split of the 40-bit difference into two halves for the shared multiplier
	localparam int HALF_W   = ACC_WIDTH / 2;
	localparam int MUL_A_W  = ACC_WIDTH - HALF_W + 1;
	localparam int MUL_B_W  = COEF_WIDTH + 1;
	localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
	localparam int PROD_W   = ACC_WIDTH + COEF_WIDTH + 1;
	localparam int SUM_W    = PROD_W + 1;
	localparam int OUT_SHIFT = GAIN_FRAC_BITS + STATE_FRAC_BITS;

	// Configuration port
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_HP_LOW  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HP_MID  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_HP_HIGH = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_LP      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_GAIN    = 3'd4;

	localparam logic [COEF_WIDTH-1:0] RST_HP_LOW  = 24'd45180;
	localparam logic [COEF_WIDTH-1:0] RST_HP_MID  = 24'd234864;
	localparam logic [COEF_WIDTH-1:0] RST_HP_HIGH = 24'd1544740;
	localparam logic [COEF_WIDTH-1:0] RST_LP      = 24'd13379830;
	localparam logic [COEF_WIDTH-1:0] RST_GAIN    = 24'd4888466;

	// Section select codes: four high-pass, two low-pass, then the output gain
	localparam int SEL_W    = 3;
	localparam int HP_SECTIONS = 4;
	localparam int HP_IDX_W = 2;
	localparam logic [SEL_W-1:0] SEC_HP0  = 3'd0;
	localparam logic [SEL_W-1:0] SEC_HP1  = 3'd1;
	localparam logic [SEL_W-1:0] SEC_HP2  = 3'd2;
	localparam logic [SEL_W-1:0] SEC_HP3  = 3'd3;
	localparam logic [SEL_W-1:0] SEC_LP1  = 3'd4;
	localparam logic [SEL_W-1:0] SEC_LP2  = 3'd5;
	localparam logic [SEL_W-1:0] SEC_GAIN = 3'd6;

	typedef struct packed {
		logic [COEF_WIDTH-1:0] hp_low;
		logic [COEF_WIDTH-1:0] hp_mid;
		logic [COEF_WIDTH-1:0] hp_high;
		logic [COEF_WIDTH-1:0] lp;
		logic [COEF_WIDTH-1:0] gain;
	} cfg_t;

	typedef struct packed {
		logic             load;
		logic             diff;
		logic             mul_lo;
		logic             mul_hi;
		logic             update;
		logic             out_load;
		logic [SEL_W-1:0] sel;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

	localparam logic signed [SUM_W-1:0] ACC_MAX =
		{{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;
	localparam logic signed [SUM_W-1:0] SMP_MAX =
		{{(SUM_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SMP_MIN = ~SMP_MAX;

	// Clamp a wide value to the accumulator range
	function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [SUM_W-1:0] v);
		logic signed [ACC_WIDTH-1:0] r;
		if (v > ACC_MAX) begin
			r = ACC_MAX[ACC_WIDTH-1:0];
		end else if (v < ACC_MIN) begin
			r = ACC_MIN[ACC_WIDTH-1:0];
		end else begin
			r = v[ACC_WIDTH-1:0];
		end
		return r;
	endfunction

	// Clamp a wide value to the sample range
	function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
		input logic signed [SUM_W-1:0] v);
		logic signed [SAMPLE_WIDTH-1:0] r;
		if (v > SMP_MAX) begin
			r = SMP_MAX[SAMPLE_WIDTH-1:0];
		end else if (v < SMP_MIN) begin
			r = SMP_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			r = v[SAMPLE_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

>>> design/awf_ctrl.sv
// Sequencer that walks one sample through the six filter sections and the gain.
module awf_ctrl
	import awf_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
	localparam logic [ST_W-1:0] ST_DIFF = 3'd1;
	localparam logic [ST_W-1:0] ST_MLO  = 3'd2;
	localparam logic [ST_W-1:0] ST_MHI  = 3'd3;
	localparam logic [ST_W-1:0] ST_UPD  = 3'd4;
	localparam logic [ST_W-1:0] ST_OUT  = 3'd5;

	logic [ST_W-1:0]  state_q;
	logic [SEL_W-1:0] sel_q;
	logic             accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Decode commands from the current step
	always_comb begin
		cmd          = '0;
		cmd.sel      = sel_q;
		cmd.load     = accept;
		cmd.diff     = (state_q == ST_DIFF);
		cmd.mul_lo   = (state_q == ST_MLO);
		cmd.mul_hi   = (state_q == ST_MHI);
		cmd.update   = (state_q == ST_UPD);
		cmd.out_load = (state_q == ST_OUT) && !status.out_busy;
	end

	// Advance through difference, two half products and update per section
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= SEC_HP0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIFF;
						sel_q   <= SEC_HP0;
					end
				end
				ST_DIFF: begin
					state_q <= ST_MLO;
				end
				ST_MLO: begin
					state_q <= ST_MHI;
				end
				ST_MHI: begin
					state_q <= (sel_q == SEC_GAIN) ? ST_OUT : ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_DIFF;
					sel_q   <= sel_q + 1'b1;
				end
				ST_OUT: begin
					if (!status.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/awf_datapath.sv
// Filter states, shared 21x25 multiplier with accumulator, and the output register.
module awf_datapath
	import awf_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_t                           cfg,
	input  cmd_t                           cmd,
	output status_t                        status,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] weighted_out
);

	localparam logic signed [PROD_W-1:0] HALF_COEF = PROD_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [PROD_W-1:0] HALF_GAIN = PROD_W'(1) << (OUT_SHIFT - 1);

	logic signed [ACC_WIDTH-1:0]    hp_delay_q [HP_SECTIONS];
	logic signed [ACC_WIDTH-1:0]    lp_first_q;
	logic signed [ACC_WIDTH-1:0]    lp_second_q;
	logic signed [ACC_WIDTH-1:0]    v_q;
	logic signed [ACC_WIDTH-1:0]    diff_q;
	logic signed [PROD_W-1:0]       acc_q;
	logic                           restart_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] weighted_out_q;

	logic [HP_IDX_W-1:0]            hp_idx;
	logic signed [ACC_WIDTH-1:0]    st_sel;
	logic signed [ACC_WIDTH-1:0]    diff_st;
	logic [COEF_WIDTH-1:0]          coef;
	logic signed [MUL_A_W-1:0]      mul_a;
	logic signed [MUL_B_W-1:0]      mul_b;
	logic signed [MUL_P_W-1:0]      prod;
	logic signed [PROD_W-1:0]       rnd_coef;
	logic signed [PROD_W-1:0]       rnd_gain;
	logic signed [ACC_WIDTH-1:0]    new_state;
	logic signed [ACC_WIDTH-1:0]    v_load;

	assign hp_idx = cmd.sel[HP_IDX_W-1:0];

	// Select the state of the active section
	always_comb begin
		case (cmd.sel)
			SEC_HP0, SEC_HP1, SEC_HP2, SEC_HP3: st_sel = hp_delay_q[hp_idx];
			SEC_LP1:                            st_sel = lp_first_q;
			SEC_LP2:                            st_sel = lp_second_q;
			default:                            st_sel = '0;
		endcase
	end

	// A restarted first low-pass section starts from its own input
	assign diff_st = (cmd.sel == SEC_LP1 && restart_q) ? v_q : st_sel;

	// Select the coefficient of the active section
	always_comb begin
		case (cmd.sel)
			SEC_HP0, SEC_HP1: coef = cfg.hp_low;
			SEC_HP2:          coef = cfg.hp_mid;
			SEC_HP3:          coef = cfg.hp_high;
			SEC_LP1, SEC_LP2: coef = cfg.lp;
			SEC_GAIN:         coef = cfg.gain;
			default:          coef = '0;
		endcase
	end

	// Half of the difference times the coefficient; the upper half carries the sign
	assign mul_a = cmd.mul_hi ? MUL_A_W'($signed(diff_q[ACC_WIDTH-1:HALF_W]))
	                          : $signed({1'b0, diff_q[HALF_W-1:0]});
	assign mul_b = $signed({1'b0, coef});
	assign prod  = mul_a * mul_b;

	// Round half up back to the state grid and to the sample grid
	assign rnd_coef  = (acc_q + HALF_COEF) >>> COEF_FRAC_BITS;
	assign rnd_gain  = (acc_q + HALF_GAIN) >>> OUT_SHIFT;
	assign new_state = sat_acc(SUM_W'(st_sel) + SUM_W'(rnd_coef));
	assign v_load    = sat_acc(SUM_W'(sample_in) <<< STATE_FRAC_BITS);

	// Hold section states; clear high-pass delays and seed low-pass on restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HP_SECTIONS; i++) begin
				hp_delay_q[i] <= '0;
			end
			lp_first_q  <= '0;
			lp_second_q <= '0;
		end else begin
			if (cmd.load && restart) begin
				for (int i = 0; i < HP_SECTIONS; i++) begin
					hp_delay_q[i] <= '0;
				end
			end
			if (cmd.diff && cmd.sel == SEC_LP1 && restart_q) begin
				lp_first_q  <= v_q;
				lp_second_q <= v_q;
			end
			if (cmd.update) begin
				case (cmd.sel)
					SEC_HP0, SEC_HP1, SEC_HP2, SEC_HP3: hp_delay_q[hp_idx] <= new_state;
					SEC_LP1:                            lp_first_q  <= new_state;
					SEC_LP2:                            lp_second_q <= new_state;
					default: begin
					end
				endcase
			end
		end
	end

	// Running value, difference and product accumulator
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q       <= v_load;
			restart_q <= restart;
		end else if (cmd.update) begin
			v_q <= (cmd.sel[HP_IDX_W]) ? new_state : diff_q;
		end
		if (cmd.diff) begin
			diff_q <= (cmd.sel == SEC_GAIN) ? v_q
			          : sat_acc(SUM_W'(v_q) - SUM_W'(diff_st));
		end
		if (cmd.mul_lo) begin
			acc_q <= PROD_W'(prod);
		end else if (cmd.mul_hi) begin
			acc_q <= acc_q + (PROD_W'(prod) <<< HALF_W);
		end
		if (cmd.out_load) begin
			weighted_out_q <= sat_sample(SUM_W'(rnd_gain));
		end
	end

	// Output request valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_busy = out_valid_q && out_stall;
	assign out_valid       = out_valid_q;
	assign weighted_out    = weighted_out_q;

endmodule

>>> design/a_weighting_filter.sv
// A-weighting filter top level: configuration registers, sequencer and datapath.
// Each request carries one signed 24-bit sample and yields one A-weighted sample. A sample
// passes through four high-pass and two low-pass one-pole sections and an output gain, all
// on one shared 21x25 multiplier. Each section takes a difference, two half-product and an
// update step; the gain a difference, two half-product and an output step that registers
// the result, waiting while the previous one is stalled. The next sample is accepted once
// back in idle, even while a finished result still waits on the output. Raising restart with
// a sample clears the high-pass delays and seeds the low-pass sections. Coefficients must be
// written through the register port only while the filter is idle; the block does not check it.
module a_weighting_filter
	import awf_pkg::*;
(
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           restart,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] weighted_out,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ADDR_W-1:0]              paddr,
	input  logic [DATA_W-1:0]              pwdata,
	output logic [DATA_W-1:0]              prdata,
	output logic                           pready
);

	cfg_t                  cfg_q;
	cmd_t                  cmd;
	status_t               status;
	logic [REG_IDX_W-1:0]  reg_idx;
	logic                  wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Write coefficient registers; ignore addresses past the last register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hp_low  <= RST_HP_LOW;
			cfg_q.hp_mid  <= RST_HP_MID;
			cfg_q.hp_high <= RST_HP_HIGH;
			cfg_q.lp      <= RST_LP;
			cfg_q.gain    <= RST_GAIN;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HP_LOW:  cfg_q.hp_low  <= pwdata[COEF_WIDTH-1:0];
				REG_HP_MID:  cfg_q.hp_mid  <= pwdata[COEF_WIDTH-1:0];
				REG_HP_HIGH: cfg_q.hp_high <= pwdata[COEF_WIDTH-1:0];
				REG_LP:      cfg_q.lp      <= pwdata[COEF_WIDTH-1:0];
				REG_GAIN:    cfg_q.gain    <= pwdata[COEF_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (reg_idx)
			REG_HP_LOW:  prdata = DATA_W'(cfg_q.hp_low);
			REG_HP_MID:  prdata = DATA_W'(cfg_q.hp_mid);
			REG_HP_HIGH: prdata = DATA_W'(cfg_q.hp_high);
			REG_LP:      prdata = DATA_W'(cfg_q.lp);
			REG_GAIN:    prdata = DATA_W'(cfg_q.gain);
			default:     prdata = '0;
		endcase
	end

	awf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	awf_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.status       (status),
		.sample_in    (sample_in),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.weighted_out (weighted_out)
	);

endmodule

>>> tb/tb.sv
// Self-checking testbench for the A-weighting filter: scoreboard, stimulus, checks.
`timescale 1ns / 1ps

module tb
	import awf_pkg::*;
();

	localparam int IDLE_LIMIT  = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 40;

	localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	localparam logic signed [SAMPLE_WIDTH-1:0] FULL_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] FULL_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic [COEF_WIDTH-1:0] COEF_ALL_ONES = '1;

	// Tracks the filter state and holds the weighted samples still owed by the block
	class weighting_scoreboard;
		logic [COEF_WIDTH-1:0]        coef_reg [5];
		logic signed [ACC_WIDTH-1:0]  hp_delay [HP_SECTIONS];
		logic signed [ACC_WIDTH-1:0]  lp_first;
		logic signed [ACC_WIDTH-1:0]  lp_second;
		logic signed [SAMPLE_WIDTH-1:0] weighted_due [$];
		int errors;
		int checked;
		int samples;
		int restarts;
		int clipped;

		function new();
			coef_reg[REG_HP_LOW]  = RST_HP_LOW;
			coef_reg[REG_HP_MID]  = RST_HP_MID;
			coef_reg[REG_HP_HIGH] = RST_HP_HIGH;
			coef_reg[REG_LP]      = RST_LP;
			coef_reg[REG_GAIN]    = RST_GAIN;
			foreach (hp_delay[i]) hp_delay[i] = '0;
			lp_first  = '0;
			lp_second = '0;
		endfunction

		function void set_coef(logic [REG_IDX_W-1:0] idx, logic [COEF_WIDTH-1:0] value);
			// drop writes to unused addresses
			if (idx <= REG_GAIN) coef_reg[idx] = value;
		endfunction

		function longint clamp(longint v, int w);
			longint hi;
			longint lo;
			hi = (longint'(1) <<< (w - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) return hi;
			if (v < lo) return lo;
			return v;
		endfunction

		// add one half, then floor
		function longint round_shift(longint v, int s);
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		// move a section state toward its target by a Q0.24 coefficient
		function longint leak(longint state, longint target, logic [COEF_WIDTH-1:0] c);
			longint diff;
			diff = clamp(target - state, ACC_WIDTH);
			return clamp(state + round_shift(diff * longint'(c), COEF_FRAC_BITS), ACC_WIDTH);
		endfunction

		function void note_sample(logic signed [SAMPLE_WIDTH-1:0] smp, logic rst);
			longint v;
			longint a;
			longint e;
			longint f;
			longint y;
			logic [COEF_WIDTH-1:0] c;
			int i;
			samples++;
			v = clamp(longint'(smp) * (longint'(1) <<< STATE_FRAC_BITS), ACC_WIDTH);
			if (rst) begin
				restarts++;
				foreach (hp_delay[k]) hp_delay[k] = '0;
			end
			// four high-pass sections: output input minus delay, then update delay
			for (i = 0; i < HP_SECTIONS; i++) begin
				if (i < 2) c = coef_reg[REG_HP_LOW];
				else if (i == 2) c = coef_reg[REG_HP_MID];
				else c = coef_reg[REG_HP_HIGH];
				a = clamp(v - longint'(hp_delay[i]), ACC_WIDTH);
				hp_delay[i] = ACC_WIDTH'(leak(hp_delay[i], v, c));
				v = a;
			end
			// seed both low-pass sections on a track start
			if (rst) begin
				lp_first  = ACC_WIDTH'(v);
				lp_second = ACC_WIDTH'(v);
			end
			e = leak(lp_first, v, coef_reg[REG_LP]);
			lp_first = ACC_WIDTH'(e);
			f = leak(lp_second, e, coef_reg[REG_LP]);
			lp_second = ACC_WIDTH'(f);
			y = round_shift(f * longint'(coef_reg[REG_GAIN]), GAIN_FRAC_BITS + STATE_FRAC_BITS);
			if (y != clamp(y, SAMPLE_WIDTH)) clipped++;
			weighted_due.push_back(SAMPLE_WIDTH'(clamp(y, SAMPLE_WIDTH)));
		endfunction

		function void check_weighted(logic signed [SAMPLE_WIDTH-1:0] actual);
			logic signed [SAMPLE_WIDTH-1:0] want;
			if (weighted_due.size() == 0) begin
				$error("weighted_out: unexpected result %0d with no request pending", actual);
				errors++;
				return;
			end
			want = weighted_due.pop_front();
			checked++;
			if (actual !== want) begin
				$error("weighted_out: expected %0d, actual %0d", want, actual);
				errors++;
			end
		endfunction

		function void check_leftover();
			if (weighted_due.size() != 0) begin
				$error("weighted_out: %0d expected results never arrived", weighted_due.size());
				errors++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic signed [SAMPLE_WIDTH-1:0] sample_in = '0;
	logic                           restart = 1'b0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic signed [SAMPLE_WIDTH-1:0] weighted_out;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [ADDR_W-1:0]              paddr = '0;
	logic [DATA_W-1:0]              pwdata = '0;
	logic [DATA_W-1:0]              prdata;
	logic                           pready;

	weighting_scoreboard sb = new();
	bit hold_req = 1'b0;
	int holds_done = 0;
	int settings_run = 0;
	int idle_cycles = 0;
	logic signed [SAMPLE_WIDTH-1:0] walk_sample = '0;

	a_weighting_filter uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample_in(sample_in), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall), .weighted_out(weighted_out),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_weighted(weighted_out);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (psel && penable && pready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Stall the output on random segments, with one long hold-off on request
	initial begin
		int seg;
		int pct;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				holds_done++;
			end
			seg = $urandom_range(60, 5);
			case ($urandom_range(4))
				0, 1: pct = 0;
				2: pct = 20;
				3: pct = 50;
				default: pct = 85;
			endcase
			repeat (seg) begin
				out_stall <= ($urandom_range(99) < pct);
				@(posedge clk);
			end
		end
	end

	// Offer one request and hold it until accepted
	task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] smp, input logic rst);
		in_valid  <= 1'b1;
		sample_in <= smp;
		restart   <= rst;
		do @(posedge clk); while (in_stall);
		sb.note_sample(smp, rst);
	endtask

	// Mix of full-range noise, quiet signal, extremes and a slow walk
	function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
		logic signed [SAMPLE_WIDTH-1:0] s;
		case ($urandom_range(9))
			0, 1, 2: s = SAMPLE_WIDTH'($urandom);
			3, 4: s = SAMPLE_WIDTH'($signed($urandom_range(4096)) - 2048);
			5: s = $urandom_range(1) ? FULL_POS : FULL_NEG;
			default: begin
				walk_sample = SAMPLE_WIDTH'(walk_sample +
					($signed($urandom_range(131072)) - 65536));
				s = walk_sample;
			end
		endcase
		return s;
	endfunction

	// Send random requests in bursts, optionally with gaps between them
	task automatic send_random(input int count, input bit gaps);
		int left;
		int burst;
		int gap;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(24, 1);
			while (burst > 0 && left > 0) begin
				send_sample(pick_sample(), $urandom_range(31) == 0);
				burst--;
				left--;
			end
			gap = gaps ? $urandom_range(6) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Extremes, sign patterns and track starts
	task automatic send_directed();
		send_sample('0, 1'b1);
		repeat (4) send_sample(FULL_POS, 1'b0);
		send_sample(FULL_NEG, 1'b1);
		repeat (3) send_sample(FULL_NEG, 1'b0);
		send_sample(24'sd1, 1'b1);
		send_sample(-24'sd1, 1'b0);
		repeat (3) begin
			send_sample(FULL_POS, 1'b0);
			send_sample(FULL_NEG, 1'b0);
		end
		send_sample(24'h555555, 1'b0);
		send_sample(24'haaaaaa, 1'b0);
		send_sample(FULL_POS, 1'b1);
		repeat (2) send_sample('0, 1'b0);
	endtask

	// Wait until every result is in, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.weighted_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write one register, then return the bus to idle
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COEF_WIDTH-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {8'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_coef(idx, value);
		@(posedge clk);
	endtask

	// Read one register and compare, then return the bus to idle
	task automatic read_check(input logic [REG_IDX_W-1:0] idx);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== DATA_W'(sb.coef_reg[idx])) begin
			$error("prdata[%0d]: expected %0d, actual %0d", idx, sb.coef_reg[idx], prdata);
			sb.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Load a full coefficient set and read it back
	task automatic apply_settings(input logic [COEF_WIDTH-1:0] hp_low, hp_mid, hp_high, lp, gain);
		write_reg(REG_HP_LOW, hp_low);
		write_reg(REG_HP_MID, hp_mid);
		write_reg(REG_HP_HIGH, hp_high);
		write_reg(REG_LP, lp);
		write_reg(REG_GAIN, gain);
		read_check(REG_HP_LOW);
		read_check(REG_HP_MID);
		read_check(REG_HP_HIGH);
		read_check(REG_LP);
		read_check(REG_GAIN);
		settings_run++;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients
		read_check(REG_HP_LOW);
		read_check(REG_HP_MID);
		read_check(REG_HP_HIGH);
		read_check(REG_LP);
		read_check(REG_GAIN);
		settings_run++;
		send_directed();
		send_random(250, 1'b1);
		drain();

		// every coefficient at full scale; unused addresses must not disturb them
		apply_settings(COEF_ALL_ONES, COEF_ALL_ONES, COEF_ALL_ONES, COEF_ALL_ONES,
			COEF_ALL_ONES);
		write_reg(REG_SPARE_FIRST, 24'($urandom));
		write_reg(REG_SPARE_LAST, 24'($urandom));
		read_check(REG_GAIN);
		send_directed();
		send_random(120, 1'b0);
		drain();

		// every coefficient at zero
		apply_settings('0, '0, '0, '0, '0);
		send_random(120, 1'b1);
		drain();

		// two random coefficient sets
		repeat (2) begin
			apply_settings(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
				24'($urandom));
			send_random(200, $urandom_range(1));
			drain();
		end

		// back to defaults; hold the output off while requests keep coming
		apply_settings(RST_HP_LOW, RST_HP_MID, RST_HP_HIGH, RST_LP, RST_GAIN);
		send_random(100, 1'b1);
		hold_req = 1'b1;
		send_random(250, 1'b0);
		drain();

		sb.check_leftover();
		$display("Run covered %0d samples (%0d track starts, %0d clipped outputs) over %0d",
			sb.samples, sb.restarts, sb.clipped, settings_run);
		$display("coefficient settings; %0d results checked, %0d long output hold-offs.",
			sb.checked, holds_done);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
